FILE: hdl/rotation_matrix_to_euler_unit_macros.svh
// Assertion macros for the rotation matrix to Euler unit
`ifndef ROTATION_MATRIX_TO_EULER_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RME_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define RME_ASSERT(label, clk, rst_n, prop, msg)
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/rme_pkg.sv
package rme_pkg;

  localparam int CordicStages = 16;
  localparam int CellW = 28;
  localparam int ZW = 24;
  localparam int SqStages = 15;

  localparam logic signed [ZW-1:0] PiQ20 = 24'sd3294199;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

  typedef enum logic [1:0] {
    PC_REGULAR = 2'd0,
    PC_NORTH   = 2'd1,
    PC_SOUTH   = 2'd2
  } pole_case_t;

  typedef enum logic [0:0] {
    REG_POLE_THRESHOLD = 1'b0
  } reg_addr_t;

  typedef struct packed {
    logic signed [CellW-1:0] x;
    logic signed [CellW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    done;
    logic signed [15:0]      res;
  } cvec_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r02;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r22;
    logic signed [15:0] s;
    pole_case_t         pc;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 24'sd823550;
      1: r = 24'sd486170;
      2: r = 24'sd256879;
      3: r = 24'sd130396;
      4: r = 24'sd65451;
      5: r = 24'sd32757;
      6: r = 24'sd16383;
      7: r = 24'sd8192;
      8: r = 24'sd4096;
      9: r = 24'sd2048;
      10: r = 24'sd1024;
      11: r = 24'sd512;
      12: r = 24'sd256;
      13: r = 24'sd128;
      14: r = 24'sd64;
      15: r = 24'sd32;
      16: r = 24'sd16;
      17: r = 24'sd8;
      18: r = 24'sd4;
      19: r = 24'sd2;
      20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cvec_t cordic_init(input logic signed [16:0] y,
                                        input logic signed [16:0] x);
    cvec_t v;
    logic signed [CellW-1:0] xs;
    logic signed [CellW-1:0] ys;
    xs = CellW'(x) <<< 10;
    ys = CellW'(y) <<< 10;
    v.res = '0;
    v.done = 1'b0;
    v.z = '0;
    v.x = xs;
    v.y = ys;
    if (y == 17'sd0) begin
      v.done = 1'b1;
      v.res = (x < 17'sd0) ? PiQ13 : 16'sd0;
    end else if (x < 17'sd0) begin
      v.z = (y > 17'sd0) ? PiQ20 : -PiQ20;
      v.x = -xs;
      v.y = -ys;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] cordic_final(input cvec_t v,
                                                      input logic signed [15:0] lim);
    logic signed [ZW-1:0] q;
    logic signed [ZW-1:0] l;
    q = (v.z + ZW'(64)) >>> 7;
    l = ZW'(lim);
    if (v.done) q = ZW'(v.res);
    if (q > l) q = l;
    if (q < -l) q = -l;
    return 16'(q);
  endfunction

endpackage

FILE: hdl/rme_if.sv
interface rme_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] r00;
  logic signed [15:0] r02;
  logic signed [15:0] r10;
  logic signed [15:0] r11;
  logic signed [15:0] r12;
  logic signed [15:0] r20;
  logic signed [15:0] r22;
  modport source (output valid, r00, r02, r10, r11, r12, r20, r22, input ready);
  modport sink (input valid, r00, r02, r10, r11, r12, r20, r22, output ready);
endinterface

FILE: hdl/rme_out_if.sv
interface rme_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] bank_angle;
  logic signed [14:0] attitude_angle;
  logic signed [15:0] heading_angle;
  logic [1:0] pole_case;
  modport source (output valid, bank_angle, attitude_angle, heading_angle, pole_case,
                  input ready);
  modport sink (input valid, bank_angle, attitude_angle, heading_angle, pole_case,
                output ready);
endinterface

FILE: hdl/rme_sqrt_cell.sv
module rme_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  idx,
  input  logic [28:0] n_in,
  input  logic [28:0] res_in,
  output logic [28:0] n_r,
  output logic [28:0] res_r
);
  logic [28:0] bit_v;
  logic [28:0] n_nxt;
  logic [28:0] res_nxt;

  always_comb begin
    bit_v = 29'd1 << (5'd28 - (idx << 1));
    if (n_in >= res_in + bit_v) begin
      n_nxt = n_in - (res_in + bit_v);
      res_nxt = (res_in >> 1) + bit_v;
    end else begin
      n_nxt = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      res_r <= res_nxt;
    end
  end
endmodule

FILE: hdl/rme_cordic_cell.sv
module rme_cordic_cell (
  input  logic            clk,
  input  logic            en,
  input  logic [4:0]      idx,
  input  rme_pkg::cvec_t  v_in,
  output rme_pkg::cvec_t  v_r
);
  rme_pkg::cvec_t v_nxt;

  always_comb begin
    v_nxt = v_in;
    if (!v_in.done) begin
      if (v_in.y >= 0) begin
        v_nxt.x = v_in.x + (v_in.y >>> idx);
        v_nxt.y = v_in.y - (v_in.x >>> idx);
        v_nxt.z = v_in.z + rme_pkg::atan_q20(int'(idx));
      end else begin
        v_nxt.x = v_in.x - (v_in.y >>> idx);
        v_nxt.y = v_in.y + (v_in.x >>> idx);
        v_nxt.z = v_in.z - rme_pkg::atan_q20(int'(idx));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) v_r <= v_nxt;
  end
endmodule

FILE: hdl/rotation_matrix_to_euler_unit.sv
// Pipeline: input register, 15 square root cells, CORDIC input register,
// 16 CORDIC cells, output register; one chain of cells, three CORDIC rows.
// Throughput: one transfer per cycle; the whole chain advances only when
// the output register is free or being taken. Reset (rst_n, synchronous,
// active low) clears valid bits and sets pole_threshold to 16351.
`include "rotation_matrix_to_euler_unit_macros.svh"
module rotation_matrix_to_euler_unit (
  input  logic        clk,
  input  logic        rst_n,
  rme_in_if.sink      in_ch,
  rme_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int SQ = rme_pkg::SqStages;
  localparam int CS = rme_pkg::CordicStages;
  localparam int DEPTH = 1 + SQ + 1 + CS + 1;

  logic [14:0] thr_r;
  logic        adv;
  logic [DEPTH-1:0] vld_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rme_pkg::REG_POLE_THRESHOLD) ?
                      {17'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 15'd16351;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr[2] == rme_pkg::REG_POLE_THRESHOLD)
      thr_r <= cfg_pwdata[14:0];
  end

  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
  end

  // stage 0: classify and form 1 - s*s
  rme_pkg::side_t side0_r;
  logic [28:0]    sq0_r;
  rme_pkg::side_t side_in;
  logic signed [16:0] m10;
  logic signed [16:0] thx;
  logic signed [15:0] s_c;
  logic signed [31:0] ss;

  always_comb begin
    m10 = 17'(in_ch.r10);
    thx = {2'b00, thr_r};
    s_c = in_ch.r10;
    if (in_ch.r10 > 16'sd16384) s_c = 16'sd16384;
    if (in_ch.r10 < -16'sd16384) s_c = -16'sd16384;
    ss = s_c * s_c;
    side_in.r00 = in_ch.r00;
    side_in.r02 = in_ch.r02;
    side_in.r11 = in_ch.r11;
    side_in.r12 = in_ch.r12;
    side_in.r20 = in_ch.r20;
    side_in.r22 = in_ch.r22;
    side_in.s = s_c;
    if (m10 > thx) side_in.pc = rme_pkg::PC_NORTH;
    else if (m10 < -thx) side_in.pc = rme_pkg::PC_SOUTH;
    else side_in.pc = rme_pkg::PC_REGULAR;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side0_r <= side_in;
      sq0_r <= 29'((33'd1 << 28) - 33'(ss));
    end
  end

  rme_pkg::side_t side_sq [SQ+1];
  logic [28:0] n_sq [SQ+1];
  logic [28:0] r_sq [SQ+1];
  assign side_sq[0] = side0_r;
  assign n_sq[0] = sq0_r;
  assign r_sq[0] = '0;

  for (genvar g = 0; g < SQ; g++) begin : g_sq
    rme_sqrt_cell u_cell (
      .clk(clk), .en(adv), .idx(5'(g)),
      .n_in(n_sq[g]), .res_in(r_sq[g]),
      .n_r(n_sq[g+1]), .res_r(r_sq[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) side_sq[g+1] <= side_sq[g];
    end
  end

  rme_pkg::side_t sd;
  rme_pkg::cvec_t cb_in, ca_in, ch_in;
  assign sd = side_sq[SQ];

  always_comb begin
    if (sd.pc == rme_pkg::PC_REGULAR) begin
      cb_in = rme_pkg::cordic_init(-17'(sd.r12), 17'(sd.r11));
      ch_in = rme_pkg::cordic_init(-17'(sd.r20), 17'(sd.r00));
    end else begin
      cb_in = rme_pkg::cordic_init(17'sd0, 17'sd0);
      ch_in = rme_pkg::cordic_init(17'(sd.r02), 17'(sd.r22));
    end
    ca_in = rme_pkg::cordic_init(17'(sd.s), 17'(r_sq[SQ][16:0]));
  end

  rme_pkg::cvec_t cb [CS+1];
  rme_pkg::cvec_t ca [CS+1];
  rme_pkg::cvec_t chd [CS+1];
  rme_pkg::pole_case_t pc_p [CS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cb[0] <= cb_in;
      ca[0] <= ca_in;
      chd[0] <= ch_in;
      pc_p[0] <= sd.pc;
    end
  end

  for (genvar g = 0; g < CS; g++) begin : g_cordic
    rme_cordic_cell u_b (.clk(clk), .en(adv), .idx(5'(g)), .v_in(cb[g]), .v_r(cb[g+1]));
    rme_cordic_cell u_a (.clk(clk), .en(adv), .idx(5'(g)), .v_in(ca[g]), .v_r(ca[g+1]));
    rme_cordic_cell u_h (.clk(clk), .en(adv), .idx(5'(g)), .v_in(chd[g]),
                         .v_r(chd[g+1]));
    always_ff @(posedge clk) begin
      if (adv) pc_p[g+1] <= pc_p[g];
    end
  end

  logic signed [15:0] att_w;
  always_comb begin
    unique case (pc_p[CS])
      rme_pkg::PC_NORTH: att_w = rme_pkg::HalfPiQ13;
      rme_pkg::PC_SOUTH: att_w = -rme_pkg::HalfPiQ13;
      default: att_w = rme_pkg::cordic_final(ca[CS], rme_pkg::HalfPiQ13);
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.bank_angle <= rme_pkg::cordic_final(cb[CS], rme_pkg::PiQ13);
      out_ch.attitude_angle <= att_w[14:0];
      out_ch.heading_angle <= rme_pkg::cordic_final(chd[CS], rme_pkg::PiQ13);
      out_ch.pole_case <= pc_p[CS];
    end
  end
  assign out_ch.valid = vld_r[DEPTH-1];

  `RME_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
  `RME_ASSERT(a_rdy, clk, rst_n, in_ch.ready == (!out_ch.valid || out_ch.ready), "ready mismatch")
  `RME_ASSERT(a_pole_bank, clk, rst_n, !(out_ch.valid && out_ch.pole_case != rme_pkg::PC_REGULAR) || out_ch.bank_angle == 16'sd0, "pole bank nonzero")
endmodule
